// ----- design/rafup_pkg.sv -----
// Package for the random axis generator built from a uniform pair.
// Holds the fixed angle field width used by the design; no dependencies.
`default_nettype none

package rafup_pkg;

  localparam int unsigned ANGLE_WIDTH = 16;

endpackage

`default_nettype wire

// ----- design/random_axis_from_uniform_pair_top.sv -----
// Top level of the random axis generator (sphere point picking from a uniform pair).
// Depends on rafup_pkg for the angle width; contains the whole pipeline.
// Accepts one draw per cycle while in_stall_o is low; gives one unit axis per accepted pair.
//
// Usage:
// The input channel carries an angle draw and two signed coordinate draws with
// COORD_WIDTH-1 fraction bits. A transfer happens when in_valid_i is high and
// in_stall_o is low. The output channel gives the angle and the x, y and z
// components of a unit axis; a transfer happens when out_valid_o is high and
// out_stall_i is low.
// Pairs whose squared length is one or more are dropped, so no result
// leaves the block for them.
// One pair is taken every cycle while in_stall_o is low. The depth is set by the
// square root, which resolves one root bit per pipeline stage.
// Every stage holds a valid bit. When the receiver stalls, the stages that
// hold items keep them and empty stages still fill, so bubbles are squeezed
// out before in_stall_o rises. Reset clears all valid bits; the pipeline is
// then empty and ready at once.
`default_nettype none

module random_axis_from_uniform_pair_top
  import rafup_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire        [ANGLE_WIDTH-1:0] angle_draw_i,
  input  wire signed [COORD_WIDTH-1:0] first_coord_i,
  input  wire signed [COORD_WIDTH-1:0] second_coord_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic       [ANGLE_WIDTH-1:0] angle_out_o,
  output logic signed [COORD_WIDTH-1:0] axis_x_o,
  output logic signed [COORD_WIDTH-1:0] axis_y_o,
  output logic signed [COORD_WIDTH-1:0] axis_z_o
);

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned F = W - 1;
  localparam int unsigned RW = 2 * F + 2;
  localparam int unsigned EW = F + 3;
  localparam int unsigned NST = F + 7;
  localparam int unsigned ST_REJ = 3;
  localparam int unsigned ST_SQ0 = 4;
  localparam int unsigned ST_MUL = F + 5;
  localparam int unsigned ST_OUT = F + 6;

  localparam logic [RW-1:0] ONE_2F = RW'(1) << (2 * F);
  localparam logic [EW-1:0] MAG_ONE = EW'(1) << F;
  localparam logic [EW-1:0] MAG_MAX = MAG_ONE - EW'(1);

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] ang;
    logic                   negx;
    logic                   negy;
    logic [W-1:0]           a1;
    logic [W-1:0]           a2;
  } head_t;

  typedef struct packed {
    head_t        h;
    logic [W-1:0] z;
  } side_t;

  function automatic logic [W-1:0] encode(input logic [EW-1:0] mag, input logic neg);
    logic [EW-1:0] m;
    m = mag;
    if (neg) begin
      if (m > MAG_ONE) begin
        m = MAG_ONE;
      end
      encode = W'(EW'(0) - m);
    end else begin
      if (m > MAG_MAX) begin
        m = MAG_MAX;
      end
      encode = m[W-1:0];
    end
  endfunction

  logic [NST-1:0] v_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = !out_stall_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  logic rej;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          if (k == 0) begin
            v_q[k] <= in_valid_i;
          end else if (k == ST_REJ) begin
            v_q[k] <= v_q[k-1] && !rej;
          end else begin
            v_q[k] <= v_q[k-1];
          end
        end
      end
    end
  end

  // Stage 0: magnitudes and signs.
  head_t h0_d, h0_q;

  always_comb begin
    h0_d.ang  = angle_draw_i;
    h0_d.negx = first_coord_i[W-1];
    h0_d.negy = second_coord_i[W-1];
    h0_d.a1   = first_coord_i[W-1] ? (~first_coord_i + W'(1)) : first_coord_i;
    h0_d.a2   = second_coord_i[W-1] ? (~second_coord_i + W'(1)) : second_coord_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      h0_q <= h0_d;
    end
  end

  // Stage 1: squares.
  head_t            h1_q;
  logic [2*W-1:0]   p1_d, p2_d;
  logic [2*F:0]     sq1_q, sq2_q;

  assign p1_d = h0_q.a1 * h0_q.a1;
  assign p2_d = h0_q.a2 * h0_q.a2;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      h1_q  <= h0_q;
      sq1_q <= p1_d[2*F:0];
      sq2_q <= p2_d[2*F:0];
    end
  end

  // Stage 2: squared length.
  head_t         h2_q;
  logic [RW-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      h2_q <= h1_q;
      s_q  <= {1'b0, sq1_q} + {1'b0, sq2_q};
    end
  end

  // Stage 3: rejection, radicand and z component.
  side_t         side_q [0:F+1];
  logic [RW-1:0] rem_q  [0:F+1];
  logic [RW-1:0] res_q  [0:F+1];
  logic [RW-1:0] twice;
  logic [RW-1:0] zdiff;
  logic [W-1:0]  z_d;

  assign rej   = s_q >= ONE_2F;
  assign twice = s_q << 1;

  always_comb begin
    if (twice <= ONE_2F) begin
      zdiff = ONE_2F - twice;
      z_d   = encode(EW'(zdiff >> F), 1'b0);
    end else begin
      zdiff = twice - ONE_2F;
      z_d   = encode(EW'(zdiff >> F), 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_REJ]) begin
      side_q[0].h <= h2_q;
      side_q[0].z <= z_d;
      rem_q[0]    <= ONE_2F - s_q;
      res_q[0]    <= '0;
    end
  end

  // Square root: one root bit per stage.
  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    localparam logic [RW-1:0] BITV = RW'(1) << (2 * (F - j));
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d, res_d;

    assign trial = res_q[j] + BITV;

    always_comb begin
      if (rem_q[j] >= trial) begin
        rem_d = rem_q[j] - trial;
        res_d = (res_q[j] >> 1) + BITV;
      end else begin
        rem_d = rem_q[j];
        res_d = res_q[j] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_SQ0+j]) begin
        side_q[j+1] <= side_q[j];
        rem_q[j+1]  <= rem_d;
        res_q[j+1]  <= res_d;
      end
    end
  end

  // Products of the magnitudes with the root.
  side_t          sm_q;
  logic [W-1:0]   q_root;
  logic [2*W-1:0] prodx_q, prody_q;

  assign q_root = res_q[F+1][W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      sm_q    <= side_q[F+1];
      prodx_q <= side_q[F+1].h.a1 * q_root;
      prody_q <= side_q[F+1].h.a2 * q_root;
    end
  end

  // Output register.
  logic [ANGLE_WIDTH-1:0] ang_q;
  logic [W-1:0]           x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      ang_q <= sm_q.h.ang;
      x_q   <= encode(EW'(prodx_q >> (F - 1)), sm_q.h.negx);
      y_q   <= encode(EW'(prody_q >> (F - 1)), sm_q.h.negy);
      z_q   <= sm_q.z;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign angle_out_o = ang_q;
  assign axis_x_o    = x_q;
  assign axis_y_o    = y_q;
  assign axis_z_o    = z_q;

endmodule

`default_nettype wire
